FILE: design/cscf_pkg.sv
// ============================================================================
// CAN signal extract package
// Shared widths, codes, queue sizing and the entry types that pass from the
// frame classifier through the queue to the change filter.
// ============================================================================
package cscf_pkg;

    localparam int DATA_W  = 64;
    localparam int ID_W    = 29;
    localparam int LEN_W   = 7;
    localparam int START_W = 6;
    localparam int TICK_W  = 16;
    localparam int CFG_W   = 32;
    localparam int CIDX_W  = 3;

    // Ticks since the last result after which an unchanged value is sent again.
    // Zero turns the heartbeat off.
    localparam logic [TICK_W-1:0] HEARTBEAT_TICKS = 16'd1024;

    // Queue between the classifier and the filter; a power of two.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef enum logic [CIDX_W-1:0] {
        CFG_RULE_ENABLED  = 3'd0,
        CFG_CHANNEL_MATCH = 3'd1,
        CFG_ID_MATCH_MODE = 3'd2,
        CFG_TARGET_ID     = 3'd3,
        CFG_START_BIT     = 3'd4,
        CFG_BIT_LENGTH    = 3'd5,
        CFG_BIG_ENDIAN    = 3'd6,
        CFG_SIGNAL_SIGNED = 3'd7
    } t_cfg_index;

    typedef enum logic {
        OP_FRAME = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        CH_ANY  = 2'd0,
        CH_ZERO = 2'd1,
        CH_ONE  = 2'd2,
        CH_NONE = 2'd3
    } t_chan_match;

    typedef enum logic [1:0] {
        ID_ANY  = 2'd0,
        ID_STD  = 2'd1,
        ID_EXT  = 2'd2,
        ID_NONE = 2'd3
    } t_id_mode;

    typedef struct packed {
        logic              is_tick;
        logic [DATA_W-1:0] raw;
        logic [DATA_W-1:0] value;
        logic [ID_W-1:0]   id;
        logic              channel;
    } t_entry;

    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_head;

endpackage

FILE: design/cscf_front.sv
// ============================================================================
// CAN signal extract front end
// Holds the rule registers, filters frames by channel and identifier and
// pulls the signal out of the payload. Ticks and matching frames are queued.
// ============================================================================
module cscf_front import cscf_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [CIDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic                i_in_valid,
    input  logic                i_full,
    input  logic                i_operation,
    input  logic                i_channel,
    input  logic [ID_W-1:0]     i_frame_id,
    input  logic                i_frame_extended,
    input  logic [3:0]          i_frame_length,
    input  logic [DATA_W-1:0]   i_frame_data,
    output t_push               o_push
);

    logic                r_rule_enabled;
    t_chan_match         r_channel_match;
    t_id_mode            r_id_match_mode;
    logic [ID_W-1:0]     r_target_id;
    logic [START_W-1:0]  r_start_bit;
    logic [LEN_W-1:0]    r_bit_length;
    logic                r_big_endian;
    logic                r_signal_signed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule_enabled  <= 1'b0;
            r_channel_match <= CH_ANY;
            r_id_match_mode <= ID_ANY;
            r_target_id     <= '0;
            r_start_bit     <= '0;
            r_bit_length    <= 7'd8;
            r_big_endian    <= 1'b0;
            r_signal_signed <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_RULE_ENABLED:  r_rule_enabled  <= i_cfg_data[0];
                CFG_CHANNEL_MATCH: r_channel_match <= t_chan_match'(i_cfg_data[1:0]);
                CFG_ID_MATCH_MODE: r_id_match_mode <= t_id_mode'(i_cfg_data[1:0]);
                CFG_TARGET_ID:     r_target_id     <= i_cfg_data[ID_W-1:0];
                CFG_START_BIT:     r_start_bit     <= i_cfg_data[START_W-1:0];
                CFG_BIT_LENGTH:    r_bit_length    <= i_cfg_data[LEN_W-1:0];
                CFG_BIG_ENDIAN:    r_big_endian    <= i_cfg_data[0];
                CFG_SIGNAL_SIGNED: r_signal_signed <= i_cfg_data[0];
                default:           r_rule_enabled  <= r_rule_enabled;
            endcase
        end
    end

    logic [3:0]          nbytes;
    logic [DATA_W-1:0]   data_m;
    logic [DATA_W-1:0]   data_mot;
    logic [DATA_W-1:0]   shift_i;
    logic [DATA_W-1:0]   shift_m;
    logic [DATA_W-1:0]   rev_m;
    logic [DATA_W-1:0]   len_mask;
    logic [DATA_W-1:0]   raw;
    logic [DATA_W-1:0]   value;
    logic [LEN_W-1:0]    len_rem;
    logic [START_W-1:0]  sign_idx;
    logic                chan_ok;
    logic                id_ok;
    logic                len_ok;
    logic                is_tick;

    // Bytes past the frame length are zeroed first. For Motorola order each
    // byte is bit-reversed so that an ascending index walks the signal MSB
    // first; the walked bits are then reversed and aligned to the length.
    always_comb begin
        nbytes = (i_frame_length > 4'd8) ? 4'd8 : i_frame_length;
        for (int b = 0; b < 8; b++) begin
            data_m[b*8 +: 8] = (4'(b) < nbytes) ? i_frame_data[b*8 +: 8] : 8'h00;
        end
        for (int b = 0; b < 8; b++) begin
            for (int p = 0; p < 8; p++) begin
                data_mot[b*8 + p] = data_m[b*8 + 7 - p];
            end
        end
        len_rem  = 7'd64 - r_bit_length;
        len_mask = {DATA_W{1'b1}} >> len_rem;
        shift_i  = data_m >> r_start_bit;
        shift_m  = data_mot >> r_start_bit;
        for (int i = 0; i < DATA_W; i++) begin
            rev_m[i] = shift_m[DATA_W-1-i];
        end
        raw      = r_big_endian ? (rev_m >> len_rem) : (shift_i & len_mask);
        sign_idx = START_W'(r_bit_length - 7'd1);
        value    = (r_signal_signed && raw[sign_idx]) ? (raw | ~len_mask) : raw;
    end

    always_comb begin
        unique case (r_channel_match)
            CH_ANY:  chan_ok = 1'b1;
            CH_ZERO: chan_ok = !i_channel;
            CH_ONE:  chan_ok = i_channel;
            CH_NONE: chan_ok = 1'b0;
            default: chan_ok = 1'b0;
        endcase
        unique case (r_id_match_mode)
            ID_ANY:  id_ok = 1'b1;
            ID_STD:  id_ok = (i_frame_id == r_target_id) && !i_frame_extended;
            ID_EXT:  id_ok = (i_frame_id == r_target_id) && i_frame_extended;
            ID_NONE: id_ok = 1'b0;
            default: id_ok = 1'b0;
        endcase
        len_ok  = (r_bit_length != '0) && (r_bit_length <= 7'd64);
        is_tick = (t_op'(i_operation) == OP_TICK);
    end

    always_comb begin
        o_push.push = i_in_valid && !i_full &&
                      (is_tick || (r_rule_enabled && chan_ok && id_ok && len_ok));
        o_push.entry.is_tick = is_tick;
        o_push.entry.raw     = raw;
        o_push.entry.value   = value;
        o_push.entry.id      = i_frame_id;
        o_push.entry.channel = i_channel;
    end

endmodule

FILE: design/cscf_queue.sv
// ============================================================================
// CAN signal extract queue
// Small first-in first-out buffer of classified items between the front end
// and the change filter.
// ============================================================================
module cscf_queue import cscf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output t_head o_head,
    output logic  o_full
);

    t_entry          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            if (i_push.push && !i_pop) begin
                r_count <= r_count + (Q_AW+1)'(1);
            end else if (i_pop && !i_push.push) begin
                r_count <= r_count - (Q_AW+1)'(1);
            end
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd_ptr];
    assign o_full       = (r_count == (Q_AW+1)'(Q_DEPTH));

endmodule

FILE: design/cscf_back.sv
// ============================================================================
// CAN signal extract change filter
// Keeps the last sent value and the tick counter, decides whether a queued
// frame is published and holds the result in the output register.
// ============================================================================
module cscf_back import cscf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_head             i_head,
    input  logic              i_out_stall,
    output logic              o_pop,
    output logic              o_out_valid,
    output logic [DATA_W-1:0] o_signal_raw,
    output logic [DATA_W-1:0] o_signal_value,
    output logic              o_publish_reason,
    output logic [ID_W-1:0]   o_source_id,
    output logic              o_source_channel
);

    logic [DATA_W-1:0] r_last_value;
    logic              r_has_value;
    logic [TICK_W-1:0] r_ticks;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_signal_raw;
    logic [DATA_W-1:0] r_signal_value;
    logic              r_publish_reason;
    logic [ID_W-1:0]   r_source_id;
    logic              r_source_channel;

    logic out_free;
    logic changed;
    logic beat;
    logic emit;
    logic load;
    logic tick_pop;

    always_comb begin
        out_free = !r_out_valid || !i_out_stall;
        changed  = !r_has_value || (r_last_value != i_head.entry.raw);
        beat     = (HEARTBEAT_TICKS != '0) && (r_ticks >= HEARTBEAT_TICKS);
        emit     = i_head.valid && !i_head.entry.is_tick && (changed || beat);
        load     = emit && out_free;
        o_pop    = i_head.valid && (i_head.entry.is_tick || !emit || out_free);
        tick_pop = i_head.valid && i_head.entry.is_tick;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_value <= '0;
            r_has_value  <= 1'b0;
            r_ticks      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (load) begin
                r_last_value <= i_head.entry.raw;
                r_has_value  <= 1'b1;
                r_ticks      <= '0;
            end else if (tick_pop && (r_ticks != {TICK_W{1'b1}})) begin
                r_ticks <= r_ticks + TICK_W'(1);
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_signal_raw     <= i_head.entry.raw;
            r_signal_value   <= i_head.entry.value;
            r_publish_reason <= !changed;
            r_source_id      <= i_head.entry.id;
            r_source_channel <= i_head.entry.channel;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_signal_raw     = r_signal_raw;
    assign o_signal_value   = r_signal_value;
    assign o_publish_reason = r_publish_reason;
    assign o_source_id      = r_source_id;
    assign o_source_channel = r_source_channel;

endmodule

FILE: design/can_signal_extract_change_filter.sv
// ============================================================================
// CAN signal extract with change filter
// Extracts one configured signal from CAN frames and publishes it on first
// value, on change, or when the heartbeat interval has passed.
// ============================================================================
// Usage:
// The input channel carries either a received frame or one heartbeat tick.
// A transfer takes place on a rising edge with i_in_valid high and o_in_stall
// low. Frames that fail the rule (disabled, wrong channel, wrong identifier,
// bad signal length) are dropped at the input and leave no trace.
// The configuration channel writes one rule register per transfer
// (i_cfg_valid and o_cfg_ready high); o_cfg_ready is always high, and the
// rule should only be changed while the block is idle.
// A frame accepted at the input is written into the queue and, once it is at
// the head and must publish, is loaded from there into the output register.
// Throughput: one item per cycle, sustained, as long as the output is not
// stalled. A four-entry queue decouples the input side from the output
// register, so o_in_stall rises only when that queue is full.
// When the receiver holds i_out_stall, the result stays in the output
// register unchanged; ticks and frames that publish nothing still drain from
// the queue, and the first frame that must publish waits at its head.
// Reset clears the queue, the output valid, the tick counter and the stored
// value, and returns the rule registers to their defaults (rule disabled,
// eight-bit signal).
// ============================================================================
module can_signal_extract_change_filter import cscf_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CIDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data,
    // Input item channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_operation,
    input  logic                i_channel,
    input  logic [ID_W-1:0]     i_frame_id,
    input  logic                i_frame_extended,
    input  logic [3:0]          i_frame_length,
    input  logic [DATA_W-1:0]   i_frame_data,
    // Result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [DATA_W-1:0]   o_signal_raw,
    output logic [DATA_W-1:0]   o_signal_value,
    output logic                o_publish_reason,
    output logic [ID_W-1:0]     o_source_id,
    output logic                o_source_channel
);

    t_push push;
    t_head head;
    logic  full;
    logic  pop;

    // Rule registers live in the front end; the write is never refused.
    assign o_cfg_ready = 1'b1;

    // The input side stalls only on a full queue, independent of i_in_valid.
    assign o_in_stall = full;

    cscf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_full           (full),
        .i_operation      (i_operation),
        .i_channel        (i_channel),
        .i_frame_id       (i_frame_id),
        .i_frame_extended (i_frame_extended),
        .i_frame_length   (i_frame_length),
        .i_frame_data     (i_frame_data),
        .o_push           (push)
    );

    cscf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full)
    );

    // The filter applies ticks and frames strictly in queue order, so the
    // stored value and the tick count always follow the accepted sequence.
    cscf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head),
        .i_out_stall      (i_out_stall),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .o_signal_raw     (o_signal_raw),
        .o_signal_value   (o_signal_value),
        .o_publish_reason (o_publish_reason),
        .o_source_id      (o_source_id),
        .o_source_channel (o_source_channel)
    );

endmodule

FILE: design/cscf_checker.sv
// ============================================================================
// CAN signal extract checker
// Port-level properties of the signal extractor, attached by bind.
// ============================================================================
module cscf_checker import cscf_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [DATA_W-1:0]   o_signal_raw,
    input logic [DATA_W-1:0]   o_signal_value,
    input logic                o_publish_reason,
    input logic [ID_W-1:0]     o_source_id,
    input logic                o_source_channel
);

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Reset empties the queue, so the input is open right after.
    a_reset_in: assert property (@(posedge i_clk) !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_signal_raw) &&
            $stable(o_signal_value) && $stable(o_publish_reason) &&
            $stable(o_source_id) && $stable(o_source_channel))
        else $error("stalled result changed");

    // Sign extension only adds ones above the raw bits.
    a_sign_ext: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_signal_value & o_signal_raw) == o_signal_raw))
        else $error("signal value does not contain raw bits");

endmodule

bind can_signal_extract_change_filter cscf_checker u_cscf_checker (.*);
